/* rtl/cpt_pkg.sv */
// Shared types and codes for the convex polygon point test.
package cpt_pkg;

  // Input transaction modes. Code 3 carries no meaning and is ignored.
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic append;
    logic start;
    logic rd_en;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic walk_last;
    logic pipe_busy;
  } sts_t;

endpackage

/* rtl/cpt_in_if.sv */
// Input channel: mode and one coordinate pair per transaction.
interface cpt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;

  modport source (output valid, output mode, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input mode, input coord_x, input coord_y, output ready);
endinterface

/* rtl/cpt_out_if.sv */
// Result channel: containment decision and overflow flag.
interface cpt_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic overflowed;

  modport source (output valid, output inside_res, output overflowed, input ready);
  modport sink   (input valid, input inside_res, input overflowed, output ready);
endinterface

/* rtl/cpt_ctrl.sv */
// Controller state machine for the convex polygon point test.
module cpt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_mode,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  cpt_pkg::sts_t  sts,
  output cpt_pkg::cmd_t  cmd
);

  cpt_pkg::state_t state_r;
  cpt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cpt_pkg::ST_IDLE: begin
        if (in_valid && (cpt_pkg::mode_t'(in_mode) == cpt_pkg::MODE_QUERY)) begin
          state_nxt = sts.count_zero ? cpt_pkg::ST_DONE : cpt_pkg::ST_WALK;
        end
      end
      cpt_pkg::ST_WALK: begin
        if (sts.walk_last) begin
          state_nxt = cpt_pkg::ST_DRAIN;
        end
      end
      cpt_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = cpt_pkg::ST_DONE;
        end
      end
      cpt_pkg::ST_DONE: begin
        if (out_ready) begin
          state_nxt = cpt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      cpt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (cpt_pkg::mode_t'(in_mode))
            cpt_pkg::MODE_CLEAR:  cmd.clear  = 1'b1;
            cpt_pkg::MODE_APPEND: cmd.append = 1'b1;
            cpt_pkg::MODE_QUERY:  cmd.start  = 1'b1;
            default: ;
          endcase
        end
      end
      cpt_pkg::ST_WALK:  cmd.rd_en = 1'b1;
      cpt_pkg::ST_DRAIN: ;
      cpt_pkg::ST_DONE:  out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

/* rtl/cpt_dp.sv */
// Datapath: vertex memory, edge walk pipeline and cross product test.
module cpt_dp #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cpt_pkg::cmd_t      cmd,
  output cpt_pkg::sts_t      sts,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  output logic               inside_res,
  output logic               overflowed
);

  localparam int EFF = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int DW  = EFF + 1;
  localparam int PW  = 2 * DW;
  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);

  logic [EFF-1:0] mem_x [MAX_VERTICES];
  logic [EFF-1:0] mem_y [MAX_VERTICES];

  logic [CW-1:0]  count_r;
  logic           ovf_r;
  logic [CW-1:0]  step_r;
  logic [EFF-1:0] px_r, py_r;

  logic [EFF-1:0] rd_x_r, rd_y_r;
  logic           v1_r, first1_r;
  logic [EFF-1:0] prev_x_r, prev_y_r;

  logic signed [DW-1:0] ex_r, ey_r, dx_r, dy_r;
  logic signed [DW-1:0] ex_nxt, ey_nxt, dx_nxt, dy_nxt;
  logic                 v2_r;

  logic signed [PW-1:0] pa_r, pb_r;
  logic                 v3_r;
  logic                 outside_r;

  logic          full;
  logic [AW-1:0] rd_addr;

  assign full    = (count_r == CW'(MAX_VERTICES));
  // The walk reads every vertex in order and then vertex 0 again for the closing edge.
  assign rd_addr = (step_r == count_r) ? '0 : step_r[AW-1:0];

  assign sts.count_zero = (count_r == '0);
  assign sts.walk_last  = (step_r == count_r);
  assign sts.pipe_busy  = v1_r | v2_r | v3_r;

  assign inside_res = ~outside_r;
  assign overflowed = ovf_r;

  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      mem_x[count_r[AW-1:0]] <= coord_x[EFF-1:0];
      mem_y[count_r[AW-1:0]] <= coord_y[EFF-1:0];
    end
    if (cmd.rd_en) begin
      rd_x_r <= mem_x[rd_addr];
      rd_y_r <= mem_y[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.clear) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.append) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= '0;
      v1_r      <= 1'b0;
      first1_r  <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      outside_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        step_r    <= '0;
        outside_r <= 1'b0;
      end else if (cmd.rd_en) begin
        step_r <= step_r + CW'(1);
      end
      v1_r     <= cmd.rd_en;
      first1_r <= (step_r == '0);
      // The first vertex only seeds the previous-vertex register.
      v2_r     <= v1_r && !first1_r;
      v3_r     <= v2_r;
      if (v3_r && (pa_r > pb_r)) begin
        outside_r <= 1'b1;
      end
    end
  end

  always_comb begin
    ex_nxt = signed'({rd_x_r[EFF-1], rd_x_r}) - signed'({prev_x_r[EFF-1], prev_x_r});
    ey_nxt = signed'({rd_y_r[EFF-1], rd_y_r}) - signed'({prev_y_r[EFF-1], prev_y_r});
    dx_nxt = signed'({px_r[EFF-1], px_r}) - signed'({prev_x_r[EFF-1], prev_x_r});
    dy_nxt = signed'({py_r[EFF-1], py_r}) - signed'({prev_y_r[EFF-1], prev_y_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px_r <= coord_x[EFF-1:0];
      py_r <= coord_y[EFF-1:0];
    end
    if (v1_r) begin
      prev_x_r <= rd_x_r;
      prev_y_r <= rd_y_r;
      ex_r     <= ex_nxt;
      ey_r     <= ey_nxt;
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
    end
    // Cross product is ex*dy - ey*dx; it is positive exactly when the first term is larger.
    pa_r <= PW'(ex_r) * PW'(dy_r);
    pb_r <= PW'(ey_r) * PW'(dx_r);
  end

endmodule

/* rtl/convex_polygon_point_test.sv */
// Top level of the convex polygon point test.
//
//   Channel   Direction  Payload
//   in_ch     sink       mode, coord_x, coord_y
//   out_ch    source     inside_res, overflowed (one per query)
//
// Clear and append transactions complete when accepted and return no result.
// A query over n stored vertices reads the vertex memory once per cycle, n + 1 reads
// for the closing edge, then drains a three-stage difference/multiply/compare pipe
// before the result is offered; the next input follows after the result handshake.
// An empty polygon answers in the following cycle.
// rst_n is synchronous; it empties the polygon and clears the overflow flag.
// The block takes no input while a query runs or its result waits on out_ch.ready.
module convex_polygon_point_test #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  cpt_in_if.sink    in_ch,
  cpt_out_if.source out_ch
);

  cpt_pkg::cmd_t cmd;
  cpt_pkg::sts_t sts;

  cpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cpt_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .coord_x    (in_ch.coord_x),
    .coord_y    (in_ch.coord_y),
    .inside_res (out_ch.inside_res),
    .overflowed (out_ch.overflowed)
  );

endmodule
